@@ rtl/quaternion_rigid_transform_defines.svh @@
// Assertion macros shared by the checker of the quaternion rigid transform.
`ifndef QUATERNION_RIGID_TRANSFORM_DEFINES_SVH
`define QUATERNION_RIGID_TRANSFORM_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define QRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define QRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qrt_pkg.sv @@
// Types, widths and constants of the quaternion rigid transform.
`timescale 1ns / 1ps
package qrt_pkg;

    localparam int POS_W      = 32;
    localparam int ROT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_SHIFT = 14;
    localparam int OUT_SHIFT  = 13;

    localparam int PROD_W    = ROT_W + POS_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int RND_W     = SUM_W - FRAC_SHIFT;
    localparam int WW_W      = 2 * ROT_W;
    localparam int WWP_W     = WW_W + POS_W;
    localparam int SCL_W     = WWP_W - 1 - FRAC_SHIFT;
    localparam int MIX_W     = RND_W + ROT_W;
    localparam int ACC_W     = MIX_W + 2;
    localparam int ROUT_W    = ACC_W - OUT_SHIFT;
    localparam int FIN_W     = ROUT_W + 1;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [ROT_W-1:0]  rot_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [RND_W-1:0]  rnd_t;
    typedef logic signed [WW_W-1:0]   ww_t;
    typedef logic signed [WWP_W-1:0]  wwp_t;
    typedef logic signed [SCL_W-1:0]  scl_t;
    typedef logic signed [MIX_W-1:0]  mix_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [ROUT_W-1:0] rout_t;
    typedef logic signed [FIN_W-1:0]  fin_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_X   = 3'd0,
        REG_ROT_Y   = 3'd1,
        REG_ROT_Z   = 3'd2,
        REG_ROT_W   = 3'd3,
        REG_TRANS_X = 3'd4,
        REG_TRANS_Y = 3'd5,
        REG_TRANS_Z = 3'd6
    } reg_idx_t;

    typedef struct packed {
        rot_t rot_x;
        rot_t rot_y;
        rot_t rot_z;
        rot_t rot_w;
        pos_t trans_x;
        pos_t trans_y;
        pos_t trans_z;
    } cfg_t;

    // Dot, cross and scaled terms handed from the front half to the back half.
    typedef struct packed {
        logic           valid;
        rnd_t           d;
        rnd_t [2:0]     c;
        wwp_t [2:0]     wwp;
    } front_t;

    localparam rot_t ROT_ONE  = rot_t'(2 ** FRAC_SHIFT);
    localparam ww_t  WW_BIAS  = ww_t'(2 ** (2 * FRAC_SHIFT - 1));
    localparam sum_t SUM_HALF = sum_t'(2 ** (FRAC_SHIFT - 1));
    localparam wwp_t WWP_HALF = wwp_t'(2 ** (FRAC_SHIFT - 1));
    localparam acc_t ACC_HALF = acc_t'(2 ** (OUT_SHIFT - 1));
    localparam pos_t POS_MAX  = {1'b0, {(POS_W - 1){1'b1}}};
    localparam pos_t POS_MIN  = {1'b1, {(POS_W - 1){1'b0}}};

endpackage

@@ rtl/qrt_point_if.sv @@
// Stream interface that carries input points.
`timescale 1ns / 1ps
interface qrt_point_if;
    logic              valid;
    logic              ready;
    qrt_pkg::pos_t     pos_x;
    qrt_pkg::pos_t     pos_y;
    qrt_pkg::pos_t     pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

@@ rtl/qrt_result_if.sv @@
// Stream interface that carries transformed points.
`timescale 1ns / 1ps
interface qrt_result_if;
    logic              valid;
    logic              ready;
    qrt_pkg::pos_t     out_x;
    qrt_pkg::pos_t     out_y;
    qrt_pkg::pos_t     out_z;
    logic              overflow;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output overflow, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input overflow, output ready);
endinterface

@@ rtl/qrt_front.sv @@
// Front half: quaternion by point products, then dot, cross and w-term scaling.
`timescale 1ns / 1ps
module qrt_front (
    input  logic                 clk,
    input  logic                 rst_n,
    qrt_point_if.sink            point,
    input  qrt_pkg::cfg_t        cfg,
    output qrt_pkg::front_t      fwd,
    input  logic                 fwd_ready
);

    logic                        en_a;
    logic                        en_b;

    logic                        a_v_reg;
    qrt_pkg::pos_t  [2:0]        p_reg;
    qrt_pkg::prod_t [2:0]        dot_reg;
    qrt_pkg::prod_t [2:0]        cxp_reg;
    qrt_pkg::prod_t [2:0]        cxn_reg;
    qrt_pkg::ww_t                ww_reg;

    qrt_pkg::pos_t  [2:0]        p_next;
    qrt_pkg::prod_t [2:0]        dot_next;
    qrt_pkg::prod_t [2:0]        cxp_next;
    qrt_pkg::prod_t [2:0]        cxn_next;
    qrt_pkg::ww_t                ww_next;

    logic                        b_v_reg;
    qrt_pkg::rnd_t               d_reg;
    qrt_pkg::rnd_t  [2:0]        c_reg;
    qrt_pkg::wwp_t  [2:0]        wwp_reg;

    qrt_pkg::rnd_t               d_next;
    qrt_pkg::rnd_t  [2:0]        c_next;
    qrt_pkg::wwp_t  [2:0]        wwp_next;

    // A stage may take new data when it is empty or its content moves on.
    assign en_b        = !b_v_reg || fwd_ready;
    assign en_a        = !a_v_reg || en_b;
    assign point.ready = en_a;

    always_comb
    begin
        qrt_pkg::rot_t [2:0] q;
        q[0] = cfg.rot_x;
        q[1] = cfg.rot_y;
        q[2] = cfg.rot_z;
        p_next[0] = point.pos_x;
        p_next[1] = point.pos_y;
        p_next[2] = point.pos_z;
        for (int i = 0; i < 3; i++)
        begin
            dot_next[i] = qrt_pkg::prod_t'(q[i]) * qrt_pkg::prod_t'(p_next[i]);
        end
        cxp_next[0] = qrt_pkg::prod_t'(q[1]) * qrt_pkg::prod_t'(p_next[2]);
        cxn_next[0] = qrt_pkg::prod_t'(q[2]) * qrt_pkg::prod_t'(p_next[1]);
        cxp_next[1] = qrt_pkg::prod_t'(q[2]) * qrt_pkg::prod_t'(p_next[0]);
        cxn_next[1] = qrt_pkg::prod_t'(q[0]) * qrt_pkg::prod_t'(p_next[2]);
        cxp_next[2] = qrt_pkg::prod_t'(q[0]) * qrt_pkg::prod_t'(p_next[1]);
        cxn_next[2] = qrt_pkg::prod_t'(q[1]) * qrt_pkg::prod_t'(p_next[0]);
        ww_next = qrt_pkg::ww_t'(cfg.rot_w) * qrt_pkg::ww_t'(cfg.rot_w) - qrt_pkg::WW_BIAS;
    end

    // Rounding to nearest is the top bits of the sum once half an LSB is added.
    always_comb
    begin
        qrt_pkg::sum_t       dsum;
        qrt_pkg::sum_t [2:0] csum;
        dsum = qrt_pkg::sum_t'(dot_reg[0]) + qrt_pkg::sum_t'(dot_reg[1])
             + qrt_pkg::sum_t'(dot_reg[2]) + qrt_pkg::SUM_HALF;
        d_next = qrt_pkg::rnd_t'(dsum[qrt_pkg::SUM_W-1:qrt_pkg::FRAC_SHIFT]);
        for (int i = 0; i < 3; i++)
        begin
            csum[i] = qrt_pkg::sum_t'(cxp_reg[i]) - qrt_pkg::sum_t'(cxn_reg[i])
                    + qrt_pkg::SUM_HALF;
            c_next[i] = qrt_pkg::rnd_t'(csum[i][qrt_pkg::SUM_W-1:qrt_pkg::FRAC_SHIFT]);
            wwp_next[i] = qrt_pkg::wwp_t'(ww_reg) * qrt_pkg::wwp_t'(p_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_v_reg <= point.valid;
            end
            if (en_b)
            begin
                b_v_reg <= a_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a && point.valid)
        begin
            p_reg   <= p_next;
            dot_reg <= dot_next;
            cxp_reg <= cxp_next;
            cxn_reg <= cxn_next;
            ww_reg  <= ww_next;
        end
        if (en_b && a_v_reg)
        begin
            d_reg   <= d_next;
            c_reg   <= c_next;
            wwp_reg <= wwp_next;
        end
    end

    assign fwd.valid = b_v_reg;
    assign fwd.d     = d_reg;
    assign fwd.c     = c_reg;
    assign fwd.wwp   = wwp_reg;

endmodule

@@ rtl/qrt_back.sv @@
// Back half: mixing products, final rounding, translation and saturation.
`timescale 1ns / 1ps
module qrt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qrt_pkg::front_t      fwd,
    output logic                 fwd_ready,
    input  qrt_pkg::cfg_t        cfg,
    qrt_result_if.source         result
);

    logic                        en_c;
    logic                        en_d;
    logic                        en_e;

    logic                        c_v_reg;
    qrt_pkg::scl_t [2:0]         s_reg;
    qrt_pkg::mix_t [2:0]         dq_reg;
    qrt_pkg::mix_t [2:0]         wc_reg;
    qrt_pkg::scl_t [2:0]         s_next;
    qrt_pkg::mix_t [2:0]         dq_next;
    qrt_pkg::mix_t [2:0]         wc_next;

    logic                        d_v_reg;
    qrt_pkg::rout_t [2:0]        r_reg;
    qrt_pkg::rout_t [2:0]        r_next;

    logic                        e_v_reg;
    qrt_pkg::pos_t [2:0]         out_reg;
    logic                        ovf_reg;
    qrt_pkg::pos_t [2:0]         out_next;
    logic                        ovf_next;

    assign en_e      = !e_v_reg || result.ready;
    assign en_d      = !d_v_reg || en_e;
    assign en_c      = !c_v_reg || en_d;
    assign fwd_ready = en_c;

    always_comb
    begin
        qrt_pkg::rot_t [2:0] q;
        qrt_pkg::wwp_t       wr;
        q[0] = cfg.rot_x;
        q[1] = cfg.rot_y;
        q[2] = cfg.rot_z;
        for (int i = 0; i < 3; i++)
        begin
            wr = fwd.wwp[i] + qrt_pkg::WWP_HALF;
            s_next[i]  = qrt_pkg::scl_t'(wr[qrt_pkg::WWP_W-2:qrt_pkg::FRAC_SHIFT]);
            dq_next[i] = qrt_pkg::mix_t'(fwd.d) * qrt_pkg::mix_t'(q[i]);
            wc_next[i] = qrt_pkg::mix_t'(cfg.rot_w) * qrt_pkg::mix_t'(fwd.c[i]);
        end
    end

    // The final shift by 13 rather than 14 folds in the factor of two.
    always_comb
    begin
        qrt_pkg::acc_t acc;
        for (int i = 0; i < 3; i++)
        begin
            acc = qrt_pkg::acc_t'(s_reg[i]) + qrt_pkg::acc_t'(dq_reg[i])
                + qrt_pkg::acc_t'(wc_reg[i]) + qrt_pkg::ACC_HALF;
            r_next[i] = qrt_pkg::rout_t'(acc[qrt_pkg::ACC_W-1:qrt_pkg::OUT_SHIFT]);
        end
    end

    always_comb
    begin
        qrt_pkg::pos_t [2:0] t;
        qrt_pkg::fin_t       fin;
        t[0] = cfg.trans_x;
        t[1] = cfg.trans_y;
        t[2] = cfg.trans_z;
        ovf_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            fin = qrt_pkg::fin_t'(r_reg[i]) + qrt_pkg::fin_t'(t[i]);
            if (fin > qrt_pkg::fin_t'(qrt_pkg::POS_MAX))
            begin
                out_next[i] = qrt_pkg::POS_MAX;
                ovf_next    = 1'b1;
            end
            else if (fin < qrt_pkg::fin_t'(qrt_pkg::POS_MIN))
            begin
                out_next[i] = qrt_pkg::POS_MIN;
                ovf_next    = 1'b1;
            end
            else
            begin
                out_next[i] = fin[qrt_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            if (en_c)
            begin
                c_v_reg <= fwd.valid;
            end
            if (en_d)
            begin
                d_v_reg <= c_v_reg;
            end
            if (en_e)
            begin
                e_v_reg <= d_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c && fwd.valid)
        begin
            s_reg  <= s_next;
            dq_reg <= dq_next;
            wc_reg <= wc_next;
        end
        if (en_d && c_v_reg)
        begin
            r_reg <= r_next;
        end
        if (en_e && d_v_reg)
        begin
            out_reg <= out_next;
            ovf_reg <= ovf_next;
        end
    end

    assign result.valid    = e_v_reg;
    assign result.out_x    = out_reg[0];
    assign result.out_y    = out_reg[1];
    assign result.out_z    = out_reg[2];
    assign result.overflow = ovf_reg;

endmodule

@@ rtl/quaternion_rigid_transform.sv @@
// Quaternion rotation plus translation of Q16.16 points: a user takes one point per clock
// while point.ready is high. The five register stages are the quaternion by point products,
// the dot and cross sums with the w-term scaling products, the products by q and w, the
// rounded sum of the three terms, and the translation with saturation into the output
// register. Each stage moves on when it is empty or its successor moves, so points keep
// entering while a result waits, and point.ready falls only once every stage holds a
// point. The rotation and translation registers may be written only while no point is in
// flight.
`timescale 1ns / 1ps
module quaternion_rigid_transform (
    input  logic                               clk,
    input  logic                               rst_n,
    qrt_point_if.sink                          point,
    qrt_result_if.source                       result,
    input  logic                               cfg_we,
    input  logic [qrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qrt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    qrt_pkg::cfg_t       cfg_reg;
    qrt_pkg::front_t     fwd;
    logic                fwd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rot_x   <= '0;
            cfg_reg.rot_y   <= '0;
            cfg_reg.rot_z   <= '0;
            cfg_reg.rot_w   <= qrt_pkg::ROT_ONE;
            cfg_reg.trans_x <= '0;
            cfg_reg.trans_y <= '0;
            cfg_reg.trans_z <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qrt_pkg::REG_ROT_X:   cfg_reg.rot_x   <= cfg_data[qrt_pkg::ROT_W-1:0];
                qrt_pkg::REG_ROT_Y:   cfg_reg.rot_y   <= cfg_data[qrt_pkg::ROT_W-1:0];
                qrt_pkg::REG_ROT_Z:   cfg_reg.rot_z   <= cfg_data[qrt_pkg::ROT_W-1:0];
                qrt_pkg::REG_ROT_W:   cfg_reg.rot_w   <= cfg_data[qrt_pkg::ROT_W-1:0];
                qrt_pkg::REG_TRANS_X: cfg_reg.trans_x <= cfg_data[qrt_pkg::POS_W-1:0];
                qrt_pkg::REG_TRANS_Y: cfg_reg.trans_y <= cfg_data[qrt_pkg::POS_W-1:0];
                qrt_pkg::REG_TRANS_Z: cfg_reg.trans_z <= cfg_data[qrt_pkg::POS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    qrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point),
        .cfg       (cfg_reg),
        .fwd       (fwd),
        .fwd_ready (fwd_ready)
    );

    qrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fwd       (fwd),
        .fwd_ready (fwd_ready),
        .cfg       (cfg_reg),
        .result    (result)
    );

endmodule

@@ rtl/qrt_checker.sv @@
// Port-level checker for the quaternion rigid transform, bound to the top level.
`timescale 1ns / 1ps
`include "quaternion_rigid_transform_defines.svh"
module qrt_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_ready,
    input  logic              res_valid,
    input  logic              res_ready,
    input  qrt_pkg::pos_t     out_x,
    input  qrt_pkg::pos_t     out_y,
    input  qrt_pkg::pos_t     out_z,
    input  logic              overflow
);

    // A stalled result transaction keeps its payload.
    `QRT_ASSERT_NXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(overflow), "stalled result changed")

    // Overflow is only ever reported together with a clamped coordinate.
    `QRT_ASSERT_IMP(a_overflow_clamped, res_valid && overflow, out_x == qrt_pkg::POS_MAX || out_x == qrt_pkg::POS_MIN || out_y == qrt_pkg::POS_MAX || out_y == qrt_pkg::POS_MIN || out_z == qrt_pkg::POS_MAX || out_z == qrt_pkg::POS_MIN, "overflow without a clamped coordinate")

    // With the output register empty, every stage can advance.
    `QRT_ASSERT_IMP(a_ready_when_empty, !res_valid, in_ready, "input stalled while output empty")

endmodule

bind quaternion_rigid_transform qrt_checker u_qrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (point.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .out_x     (result.out_x),
    .out_y     (result.out_y),
    .out_z     (result.out_z),
    .overflow  (result.overflow)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the quaternion rigid transform.
`timescale 1ns / 1ps
module testbench;
    import qrt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_POINTS = 50;

    typedef struct {
        pos_t coord [3];
        logic overflow;
    } placed_point_t;

    // Mirrors the transform registers and keeps the points still owed by the block.
    class transform_ledger;
        rot_t rot [3];
        rot_t rot_w;
        pos_t trans [3];
        placed_point_t awaited [$];
        int unsigned errors;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                rot[i] = '0;
                trans[i] = '0;
            end
            rot_w = ROT_ONE;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ROT_X:   rot[0] = data[ROT_W-1:0];
                REG_ROT_Y:   rot[1] = data[ROT_W-1:0];
                REG_ROT_Z:   rot[2] = data[ROT_W-1:0];
                REG_ROT_W:   rot_w = data[ROT_W-1:0];
                REG_TRANS_X: trans[0] = data;
                REG_TRANS_Y: trans[1] = data;
                REG_TRANS_Z: trans[2] = data;
                default:     ;
            endcase
        endfunction

        // Round half up, then an arithmetic shift, which floors.
        function longint round_shift(longint v, int unsigned s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function placed_point_t transform_point(pos_t px, pos_t py, pos_t pz);
            longint p [3];
            longint q [3];
            longint c [3];
            longint w, ww, d, a, r, s;
            placed_point_t res;
            p[0] = px;
            p[1] = py;
            p[2] = pz;
            for (int i = 0; i < 3; i++)
                q[i] = rot[i];
            w = rot_w;
            d = round_shift(q[0] * p[0] + q[1] * p[1] + q[2] * p[2], FRAC_SHIFT);
            c[0] = round_shift(q[1] * p[2] - q[2] * p[1], FRAC_SHIFT);
            c[1] = round_shift(q[2] * p[0] - q[0] * p[2], FRAC_SHIFT);
            c[2] = round_shift(q[0] * p[1] - q[1] * p[0], FRAC_SHIFT);
            ww = w * w - (longint'(1) << 27);
            res.overflow = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                a = round_shift(ww * p[i], FRAC_SHIFT) + d * q[i] + w * c[i];
                r = round_shift(a, OUT_SHIFT);
                s = r + longint'(trans[i]);
                if (s > longint'(POS_MAX))
                begin
                    s = POS_MAX;
                    res.overflow = 1'b1;
                end
                if (s < longint'(POS_MIN))
                begin
                    s = POS_MIN;
                    res.overflow = 1'b1;
                end
                res.coord[i] = pos_t'(s);
            end
            return res;
        endfunction

        function void note_point(pos_t px, pos_t py, pos_t pz);
            awaited.push_back(transform_point(px, py, pz));
        endfunction

        function void check_result(pos_t ox, pos_t oy, pos_t oz, logic ovf);
            placed_point_t want;
            pos_t got [3];
            string names [3];
            names = '{"out_x", "out_y", "out_z"};
            got = '{ox, oy, oz};
            if (awaited.size() == 0)
            begin
                $error("result transaction with no point awaiting a result");
                errors++;
                return;
            end
            want = awaited.pop_front();
            for (int i = 0; i < 3; i++)
                if (got[i] !== want.coord[i])
                begin
                    $error("%s: expected %0d, got %0d", names[i], want.coord[i], got[i]);
                    errors++;
                end
            if (ovf !== want.overflow)
            begin
                $error("overflow: expected %0b, got %0b", want.overflow, ovf);
                errors++;
            end
        endfunction

        function void close();
            if (awaited.size() != 0)
            begin
                $error("%0d transformed points never arrived", awaited.size());
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    qrt_point_if pt_if ();
    qrt_result_if res_if ();

    transform_ledger book = new();
    int unsigned hold_off_requests = 0;
    int unsigned hold_off_served = 0;
    int unsigned burst_left = 0;

    quaternion_rigid_transform i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (pt_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Input transactions are booked before output ones are checked within the same edge.
    always @(posedge clk)
    begin
        if (rst_n && pt_if.valid && pt_if.ready)
            book.note_point(pt_if.pos_x, pt_if.pos_y, pt_if.pos_z);
        if (rst_n && res_if.valid && res_if.ready)
            book.check_result(res_if.out_x, res_if.out_y, res_if.out_z, res_if.overflow);
    end

    // Receiver: segments of differing stall density, plus long hold-offs on request.
    initial
    begin : result_drain
        int unsigned seg_left;
        int unsigned stall_pct;
        seg_left = 0;
        stall_pct = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_served != hold_off_requests)
            begin
                hold_off_served = hold_off_requests;
                res_if.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            seg_left--;
            res_if.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    // All driving tasks start and end just after a falling edge.
    task automatic send_point(input pos_t px, input pos_t py, input pos_t pz);
        pt_if.valid = 1'b1;
        pt_if.pos_x = px;
        pt_if.pos_y = py;
        pt_if.pos_z = pz;
        @(posedge clk);
        while (!pt_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pace_sender(input bit no_gaps);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = no_gaps ? 0 : $urandom_range(0, 10);
            if (gap != 0)
            begin
                pt_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        pt_if.valid = 1'b0;
        while (book.awaited.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        book.write_reg(idx, data);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rot_word(input rot_t v);
        logic [CFG_DATA_W-1:0] w;
        w = $urandom;
        w[ROT_W-1:0] = v;
        return w;
    endfunction

    function automatic pos_t random_pos();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return pos_t'($urandom);
        if (pick < 9)
            return pos_t'($signed($urandom) >>> $urandom_range(1, 31));
        case ($urandom_range(0, 3))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    // The unused index is written every time with random data; it must change nothing.
    task automatic load_transform(input rot_t qx, input rot_t qy, input rot_t qz,
                                  input rot_t qw, input pos_t tx, input pos_t ty,
                                  input pos_t tz);
        write_reg(REG_ROT_X, rot_word(qx));
        write_reg(REG_ROT_Y, rot_word(qy));
        write_reg(REG_ROT_Z, rot_word(qz));
        write_reg(REG_NONE, $urandom);
        write_reg(REG_ROT_W, rot_word(qw));
        write_reg(REG_TRANS_X, tx);
        write_reg(REG_TRANS_Y, ty);
        write_reg(REG_TRANS_Z, tz);
    endtask

    initial
    begin : stimulus
        rot_t q [4];
        pos_t tr [3];
        real comp [4];
        real norm;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pt_if.valid = 1'b0;
        pt_if.pos_x = '0;
        pt_if.pos_y = '0;
        pt_if.pos_z = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Identity rotation out of reset: points must come back unchanged.
        send_point(0, 0, 0);
        send_point(POS_MAX, POS_MIN, -1);
        send_point(POS_MIN, POS_MAX, 1);
        send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh7fff_8000);
        wait_drained();

        // Quarter turn about z with a small shift.
        load_transform(0, 0, 11585, 11585, 65536, -65536, 0);
        send_point(65536, 0, 0);
        send_point(0, 65536, 0);
        send_point(0, 0, 65536);
        wait_drained();

        // Grossly non-unit quaternion and extreme shifts: saturation in both directions.
        load_transform(32767, 32767, 32767, -32768, POS_MAX, POS_MIN, 0);
        send_point(POS_MAX, POS_MAX, POS_MAX);
        send_point(POS_MIN, POS_MIN, POS_MIN);
        send_point(0, 0, 0);
        send_point(1, -1, 1);
        send_point(POS_MAX, POS_MIN, 0);
        wait_drained();

        load_transform(-32768, -32768, -32768, 32767, POS_MIN, POS_MAX, -1);
        send_point(POS_MIN, POS_MAX, POS_MIN);
        send_point(-1, -1, -1);
        send_point(0, 0, 0);
        send_point(32'sh0000_8000, -32'sh0000_8000, 32'sh0000_4000);
        send_point(POS_MAX, 0, POS_MIN);

        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            wait_drained();
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    for (int i = 0; i < 4; i++)
                        comp[i] = ($urandom_range(0, 20000) - 10000.0) / 10000.0;
                    norm = $sqrt(comp[0] * comp[0] + comp[1] * comp[1]
                                 + comp[2] * comp[2] + comp[3] * comp[3]);
                    for (int i = 0; i < 4; i++)
                        q[i] = (norm < 0.1) ? ((i == 3) ? ROT_ONE : rot_t'(0))
                                            : rot_t'(int'(comp[i] / norm * 16384.0));
                end
                2:
                    for (int i = 0; i < 4; i++)
                        q[i] = rot_t'($urandom);
                default:
                    for (int i = 0; i < 4; i++)
                        case ($urandom_range(0, 4))
                            0:       q[i] = -32768;
                            1:       q[i] = 32767;
                            2:       q[i] = 0;
                            3:       q[i] = 16384;
                            default: q[i] = -16384;
                        endcase
            endcase
            for (int i = 0; i < 3; i++)
                case ($urandom_range(0, 3))
                    0, 1:    tr[i] = pos_t'($signed($urandom) >>> 10);
                    2:       tr[i] = pos_t'($urandom);
                    default: tr[i] = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
                endcase
            load_transform(q[0], q[1], q[2], q[3], tr[0], tr[1], tr[2]);
            // One phase streams without gaps into a receiver that holds off, so the
            // pipeline fills and the block must push back on its input.
            if (k == 2)
                hold_off_requests++;
            burst_left = 0;
            for (int n = 0; n < PHASE_POINTS; n++)
            begin
                if (k == 5 && n == PHASE_POINTS / 2)
                    wait_drained();
                pace_sender(k == 2);
                send_point(random_pos(), random_pos(), random_pos());
            end
        end

        wait_drained();
        repeat (12) @(negedge clk);
        book.close();
        if (book.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
